// ===== rtl/rprop_pkg.sv =====
package rprop_pkg;

    // field widths
    localparam int W_IDX     = 10;
    localparam int W_STEP    = 48;
    localparam int W_WGT     = 48;
    localparam int W_GRAD    = 32;
    localparam int W_GAIN    = 16;
    localparam int W_REL     = 32;
    localparam int W_CFG_IDX = 3;

    // shared multiplier: 24 x 32 unsigned
    localparam int W_HALF    = 24;
    localparam int W_MUL_B   = 32;
    localparam int W_PROD    = W_HALF + W_MUL_B;
    localparam int W_GPROD   = W_HALF + W_GAIN;
    localparam int W_WIDE    = 64;
    localparam int GAIN_FRAC = 14;
    localparam int REL_FRAC  = 16;
    localparam int MUL_STEPS = 6;
    localparam int W_MUL_K   = 3;

    // configuration register indexes
    typedef logic [W_CFG_IDX-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_INCR_GAIN = 3'd0;
    localparam t_cfg_idx CFG_DECR_GAIN = 3'd1;
    localparam t_cfg_idx CFG_STEP_MAX  = 3'd2;
    localparam t_cfg_idx CFG_STEP_MIN  = 3'd3;
    localparam t_cfg_idx CFG_STEP_INIT = 3'd4;
    localparam t_cfg_idx CFG_REL_MAX   = 3'd5;

    // configuration reset values
    localparam logic [W_GAIN-1:0] RST_INCR_GAIN = 16'd19661;
    localparam logic [W_GAIN-1:0] RST_DECR_GAIN = 16'd5407;
    localparam logic [W_STEP-1:0] RST_STEP_MAX  = 48'd214748364800;
    localparam logic [W_STEP-1:0] RST_STEP_MIN  = 48'd4295;
    localparam logic [W_STEP-1:0] RST_STEP_INIT = 48'd4294967296;
    localparam logic [W_REL-1:0]  RST_REL_MAX   = 32'd0;

    // saturation limits
    localparam logic [W_STEP-1:0] STEP_SAT = {W_STEP{1'b1}};
    localparam logic [W_WGT-1:0]  WGT_MAX  = {1'b0, {(W_WGT-1){1'b1}}};
    localparam logic [W_WGT-1:0]  WGT_MIN  = {1'b1, {(W_WGT-1){1'b0}}};

    // gradient sign, two's complement -1 / 0 / +1
    typedef logic [1:0] t_sign;
    localparam t_sign SIGN_ZERO = 2'b00;
    localparam t_sign SIGN_POS  = 2'b01;
    localparam t_sign SIGN_NEG  = 2'b11;

    // multiplier slots
    typedef logic [W_MUL_K-1:0] t_mul_k;
    localparam t_mul_k MK_GAIN_LO = 3'd0;
    localparam t_mul_k MK_GAIN_HI = 3'd1;
    localparam t_mul_k MK_REL_LO  = 3'd2;
    localparam t_mul_k MK_REL_HI  = 3'd3;
    localparam t_mul_k MK_THR_LO  = 3'd4;
    localparam t_mul_k MK_THR_HI  = 3'd5;

    typedef struct packed {
        logic [W_IDX-1:0]         index;
        logic signed [W_WGT-1:0]  weight;
        logic signed [W_GRAD-1:0] gradient;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic signed [W_WGT-1:0] new_weight;
        logic [W_STEP-1:0]       new_step;
        logic                    sweep_end;
        logic                    converged;
    } t_result;

    // one word of the element store
    typedef struct packed {
        logic              valid;
        t_sign             sign;
        logic [W_STEP-1:0] step;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_COMB,
        S_SEL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_begin;
        logic clr_run;
        logic mul_run;
        logic comb;
        logic sel;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_pend;
        logic clr_last;
        logic mul_last;
    } t_dp_stat;

endpackage

// ===== rtl/rprop_ctrl.sv =====
module rprop_ctrl import rprop_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // state register, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_pend) begin
                    n_state = S_CLEAR;
                end else if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_stat.clr_pend) begin
                    n_state = S_CLEAR;
                end else if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_stat.mul_last) begin
                    n_state = S_COMB;
                end
            end
            S_COMB:  n_state = S_SEL;
            S_SEL:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && !i_stat.clr_pend && i_start;
        o_cmd.clr_begin = ((r_state == S_IDLE) || (r_state == S_CLEAR)) && i_stat.clr_pend;
        o_cmd.clr_run   = (r_state == S_CLEAR);
        o_cmd.mul_run   = (r_state == S_MUL);
        o_cmd.comb      = (r_state == S_COMB);
        o_cmd.sel       = (r_state == S_SEL);
        o_cmd.fin       = (r_state == S_FIN);
        o_busy          = (r_state != S_IDLE) || i_stat.clr_pend;
    end

endmodule

// ===== rtl/rprop_dp.sv =====
module rprop_dp import rprop_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  t_cfg_idx          i_cfg_index,
    input  logic [W_STEP-1:0] i_cfg_data,
    input  t_item             i_item,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_res_valid,
    output t_result           o_result
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int W_EXT = 17;

    // configuration registers
    logic [W_GAIN-1:0] r_incr_gain;
    logic [W_GAIN-1:0] r_decr_gain;
    logic [W_STEP-1:0] r_step_max;
    logic [W_STEP-1:0] r_step_min;
    logic [W_STEP-1:0] r_step_init;
    logic [W_REL-1:0]  r_rel_max;
    logic              r_clr_pend;
    logic [AW-1:0]     r_clr_cnt;
    t_mul_k            r_mul_k;

    // element store
    t_entry            mem [ENTRIES];
    t_entry            r_rdata;
    t_item             r_item;

    // working registers
    logic [W_PROD-1:0] r_prod [MUL_STEPS];
    logic [W_STEP-1:0] r_gained;
    logic [W_STEP-1:0] r_cap;
    logic [W_WIDE-1:0] r_thr;
    logic [W_STEP-1:0] r_step_new;
    logic [W_STEP-1:0] r_peak;
    t_result           r_res;
    logic              r_res_valid;

    logic [W_EXT-1:0]   in_idx_ext;
    logic [W_EXT-1:0]   cur_idx_ext;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      cur_addr;
    logic               in_range;
    logic [W_STEP-1:0]  s_cur;
    t_sign              ls_cur;
    t_sign              g_sign;
    logic               agree;
    logic               flip;
    logic [W_WGT-1:0]   w_mag;
    logic [W_GAIN-1:0]  gain_sel;
    logic [W_HALF-1:0]  mul_a;
    logic [W_MUL_B-1:0] mul_b;
    logic [W_PROD-1:0]  mul_p;
    logic [W_WIDE-1:0]  gain_full;
    logic [W_WIDE-1:0]  thr_full;
    logic [W_STEP+1:0]  gain_sh;
    logic [W_STEP-1:0]  grown;
    logic [W_STEP:0]    rel_sum;
    logic [W_STEP-1:0]  rel_cap;
    logic [W_STEP-1:0]  step_sel;
    t_sign              sign_sel;
    logic [W_WGT+1:0]   w_ext;
    logic [W_WGT+1:0]   s_ext;
    logic [W_WGT+1:0]   w_sum;
    logic [W_WGT-1:0]   w_new;
    logic [W_STEP-1:0]  peak_next;
    logic               conv;

    // addresses and range check
    assign in_idx_ext  = W_EXT'(i_item.index);
    assign cur_idx_ext = W_EXT'(r_item.index);
    assign in_addr     = in_idx_ext[AW-1:0];
    assign cur_addr    = cur_idx_ext[AW-1:0];
    assign in_range    = cur_idx_ext < W_EXT'(ENTRIES);

    // configuration writes; a step_init write requests a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incr_gain <= RST_INCR_GAIN;
            r_decr_gain <= RST_DECR_GAIN;
            r_step_max  <= RST_STEP_MAX;
            r_step_min  <= RST_STEP_MIN;
            r_step_init <= RST_STEP_INIT;
            r_rel_max   <= RST_REL_MAX;
            r_clr_pend  <= 1'b0;
        end else begin
            if (i_cmd.clr_begin) begin
                r_clr_pend <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_INCR_GAIN: r_incr_gain <= i_cfg_data[W_GAIN-1:0];
                    CFG_DECR_GAIN: r_decr_gain <= i_cfg_data[W_GAIN-1:0];
                    CFG_STEP_MAX:  r_step_max  <= i_cfg_data;
                    CFG_STEP_MIN:  r_step_min  <= i_cfg_data;
                    CFG_STEP_INIT: begin
                        r_step_init <= i_cfg_data;
                        r_clr_pend  <= 1'b1;
                    end
                    CFG_REL_MAX:   r_rel_max   <= i_cfg_data[W_REL-1:0];
                    default: ;
                endcase
            end
        end
    end

    // clearing pass counter and multiplier slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_mul_k   <= MK_GAIN_LO;
        end else begin
            if (i_cmd.clr_begin) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_run) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.mul_run) begin
                r_mul_k <= (r_mul_k == t_mul_k'(MUL_STEPS - 1)) ? MK_GAIN_LO
                                                                 : r_mul_k + t_mul_k'(1);
            end
        end
    end

    assign o_stat.clr_pend = r_clr_pend;
    assign o_stat.clr_last = (r_clr_cnt == AW'(ENTRIES - 1));
    assign o_stat.mul_last = (r_mul_k == t_mul_k'(MUL_STEPS - 1));

    // element store: clear or write back, registered read on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_run) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_cmd.sel && in_range) begin
            mem[cur_addr] <= '{valid: 1'b1, sign: sign_sel, step: step_sel};
        end
        if (i_cmd.accept) begin
            r_rdata <= mem[in_addr];
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
    end

    // fresh entries start from step_init with no sign
    assign s_cur  = r_rdata.valid ? r_rdata.step : r_step_init;
    assign ls_cur = r_rdata.valid ? r_rdata.sign : SIGN_ZERO;

    always_comb begin
        if (r_item.gradient == '0) begin
            g_sign = SIGN_ZERO;
        end else if (r_item.gradient[W_GRAD-1]) begin
            g_sign = SIGN_NEG;
        end else begin
            g_sign = SIGN_POS;
        end
    end

    assign agree    = (g_sign != SIGN_ZERO) && (ls_cur != SIGN_ZERO) && (g_sign == ls_cur);
    assign flip     = (g_sign != SIGN_ZERO) && (ls_cur != SIGN_ZERO) && (g_sign != ls_cur);
    assign w_mag    = r_item.weight[W_WGT-1] ? (~r_item.weight + W_WGT'(1)) : r_item.weight;
    assign gain_sel = agree ? r_incr_gain : r_decr_gain;

    // shared multiplier operands, one slot per cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_mul_k)
            MK_GAIN_LO: begin
                mul_a = s_cur[W_HALF-1:0];
                mul_b = W_MUL_B'(gain_sel);
            end
            MK_GAIN_HI: begin
                mul_a = s_cur[W_STEP-1:W_HALF];
                mul_b = W_MUL_B'(gain_sel);
            end
            MK_REL_LO: begin
                mul_a = w_mag[W_HALF-1:0];
                mul_b = r_rel_max;
            end
            MK_REL_HI: begin
                mul_a = w_mag[W_WGT-1:W_HALF];
                mul_b = r_rel_max;
            end
            MK_THR_LO: begin
                mul_a = r_step_min[W_HALF-1:0];
                mul_b = W_MUL_B'(r_incr_gain);
            end
            MK_THR_HI: begin
                mul_a = r_step_min[W_STEP-1:W_HALF];
                mul_b = W_MUL_B'(r_incr_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = W_PROD'(mul_a) * W_PROD'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_run) begin
            r_prod[r_mul_k] <= mul_p;
        end
    end

    // combine partial products: gain product, relative cap, convergence threshold
    assign gain_full = {r_prod[MK_GAIN_HI][W_GPROD-1:0], {W_HALF{1'b0}}}
                     + W_WIDE'(r_prod[MK_GAIN_LO][W_GPROD-1:0]);
    assign gain_sh   = gain_full[W_WIDE-1:GAIN_FRAC];
    assign grown     = (|gain_sh[W_STEP+1:W_STEP]) ? STEP_SAT : gain_sh[W_STEP-1:0];

    assign rel_sum = {1'b0, r_prod[MK_REL_HI][W_STEP-W_HALF+REL_FRAC-1:0],
                      {(W_HALF-REL_FRAC){1'b0}}}
                   + (W_STEP+1)'(r_prod[MK_REL_LO][W_PROD-1:REL_FRAC]);
    assign rel_cap = ((|r_prod[MK_REL_HI][W_PROD-1:W_STEP-W_HALF+REL_FRAC]) || rel_sum[W_STEP])
                   ? STEP_SAT : rel_sum[W_STEP-1:0];

    assign thr_full = {r_prod[MK_THR_HI][W_GPROD-1:0], {W_HALF{1'b0}}}
                    + W_WIDE'(r_prod[MK_THR_LO][W_GPROD-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.comb) begin
            r_gained <= grown;
            r_cap    <= (r_rel_max != '0) ? rel_cap : r_step_max;
            r_thr    <= thr_full;
        end
    end

    // new step and sign
    always_comb begin
        priority if (agree) begin
            step_sel = (r_gained < r_cap) ? r_gained : r_cap;
            sign_sel = g_sign;
        end else if (flip) begin
            step_sel = (r_gained > r_step_min) ? r_gained : r_step_min;
            sign_sel = SIGN_ZERO;
        end else begin
            step_sel = s_cur;
            sign_sel = g_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_step_new <= step_sel;
        end
    end

    // weight of an in-range item moves against the gradient sign, saturating
    assign w_ext = {{2{r_item.weight[W_WGT-1]}}, r_item.weight};
    assign s_ext = {2'b00, r_step_new};

    always_comb begin
        priority if (!in_range) begin
            w_sum = w_ext;
        end else if (g_sign == SIGN_POS) begin
            w_sum = w_ext - s_ext;
        end else if (g_sign == SIGN_NEG) begin
            w_sum = w_ext + s_ext;
        end else begin
            w_sum = w_ext;
        end
    end

    always_comb begin
        if ((w_sum[W_WGT+1:W_WGT-1] == 3'b000) || (w_sum[W_WGT+1:W_WGT-1] == 3'b111)) begin
            w_new = w_sum[W_WGT-1:0];
        end else if (w_sum[W_WGT+1]) begin
            w_new = WGT_MIN;
        end else begin
            w_new = WGT_MAX;
        end
    end

    // sweep peak and convergence test
    assign peak_next = (in_range && (r_step_new > r_peak)) ? r_step_new : r_peak;
    assign conv      = r_item.last
                    && ({2'b00, peak_next, {GAIN_FRAC{1'b0}}} < r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.fin;
            if (i_cmd.fin) begin
                r_peak <= r_item.last ? '0 : peak_next;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res.new_weight <= w_new;
            r_res.new_step   <= in_range ? r_step_new : '0;
            r_res.sweep_end  <= r_item.last;
            r_res.converged  <= conv;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;

endmodule

// ===== rtl/rprop_weight_update.sv =====
// Channel   Signals                                      Transfer
// ------    -------                                      --------
// item in   start, busy, i_item (t_item)                 start high and busy low
// result    o_res_valid, o_result (t_result)             o_res_valid high, one cycle
// config    i_cfg_wr_en, i_cfg_index, i_cfg_data         i_cfg_wr_en high
//
// Each item passes six slots through one shared 24x32 multiplier, then
// combine, step select with store write-back, and weight update. The result strobe
// rises in the cycle busy falls; the next item can be taken in that cycle.
// After reset, and after each step_init write, a clearing pass over all ENTRIES elements
// marks every element fresh; busy stays high meanwhile. Results cannot be stalled.
module rprop_weight_update import rprop_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_res_valid,
    output t_result           o_result,
    input  logic              i_cfg_wr_en,
    input  t_cfg_idx          i_cfg_index,
    input  logic [W_STEP-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    rprop_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // store, multiplier and update logic
    rprop_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

endmodule

// ===== rtl/rprop_chk.sv =====
module rprop_chk import rprop_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_res_valid,
    input t_result  o_result,
    input logic     i_cfg_wr_en,
    input t_cfg_idx i_cfg_index
);

    // results are single-cycle strobes, never back to back
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for two cycles");

    // an accepted item keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after item transfer");

    // converged only reported at sweep end
    a_conv_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_result.sweep_end) |-> !o_result.converged)
        else $error("converged set on a non-final result");

    // reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_res_valid))
        else $error("block not busy clearing after reset");

    // a step_init write blocks items until the store is cleared
    a_init_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wr_en && (i_cfg_index == CFG_STEP_INIT)) |=> busy)
        else $error("step_init write did not start a clearing pass");

endmodule

bind rprop_weight_update rprop_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_result    (o_result),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_cfg_index (i_cfg_index)
);
